@@ rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form with explicit clock and active-low reset.
`define ODO_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("odometry check failed");

// Short form on the block's own clock and reset.
`define ODO_ASSERT(lbl, prop) `ODO_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

@@ rtl/odo_pkg.sv @@
package odo_pkg;

  localparam int unsigned DIV_W           = 64;
  localparam int unsigned DVS_W           = 32;
  localparam int unsigned US_PER_S        = 1000000;
  localparam int unsigned CORDIC_GAIN     = 652032874;
  localparam int unsigned RAD_TO_BAM      = 683565276;
  localparam logic [19:0] WB_RESET        = 20'd32768;
  localparam int unsigned CORDIC_ITER_DEF = 16;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_L,
    OP_MUL_R,
    OP_DIV_DT,
    OP_GET_L,
    OP_GET_R,
    OP_DIV_YAW,
    OP_GET_YAW,
    OP_CINIT,
    OP_CITER,
    OP_MUL_GX,
    OP_MUL_GY,
    OP_GET_VY,
    OP_MUL_PX,
    OP_MUL_PY,
    OP_DIV_US,
    OP_GET_PX,
    OP_GET_PY,
    OP_MUL_YT,
    OP_GET_RAD,
    OP_MUL_HH,
    OP_MUL_HL,
    OP_ADD_H,
    OP_OUT
  } op_e;

  typedef enum logic [5:0] {
    S_IDLE, S_CHECK,
    S_ML, S_DL, S_WL, S_GL,
    S_MR, S_DR, S_WR, S_GR,
    S_DY, S_WY, S_GY,
    S_CI, S_CR, S_GX, S_GG, S_VY,
    S_MPX, S_DPX, S_WPX, S_GPX,
    S_MPY, S_DPY, S_WPY, S_GPY,
    S_MYT, S_DYT, S_WYT, S_GRD,
    S_HH, S_HL, S_HA, S_OUT
  } state_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic dt_zero;
    logic cmd;
    logic div_done;
    logic cordic_last;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Arctangent of 2^-i in binary-angle units.
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/odo_div.sv @@
module odo_div import odo_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]        divisor_i,
  output logic signed [DIV_W-1:0] quo_o,
  output logic                    done_o
);

  localparam int unsigned CntW = $clog2(DIV_W);

  logic             busy_q, done_q, neg_q;
  logic [CntW-1:0]  cnt_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DIV_W-1:0] quo_q;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // One quotient bit per cycle, restoring division on the magnitude.
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[DVS_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIV_W-1];
      quo_q <= dividend_i[DIV_W-1] ? DIV_W'(-dividend_i) : DIV_W'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign done_o = done_q;

endmodule

// Division by one million, truncated toward zero. The magnitude is consumed
// in four 16-bit digits, most significant first. For each digit,
// a reciprocal multiplication first gives the digit quotient, then the remainder is
// formed by subtracting the quotient times one million.
module odo_div_us import odo_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DIV_W-1:0] dividend_i,
  output logic signed [DIV_W-1:0] quo_o,
  output logic                    done_o
);

  // One million is 64 * 15625. After dropping six bits the partial value has
  // 30 bits, and 2^44 / 15625 rounded up divides any 30-bit value exactly.
  localparam logic [30:0] RecipM = 31'd1125899907;
  localparam logic [19:0] UsPerS = 20'(US_PER_S);

  logic             busy_q, done_q, phase_q, neg_q;
  logic [1:0]       dig_q;
  logic [DIV_W-1:0] mag_q, quo_q;
  logic [19:0]      rem_q;
  logic [15:0]      qd_q;
  logic [35:0]      part, back;
  logic [60:0]      est;

  assign part = {rem_q, mag_q[DIV_W-1 -: 16]};
  assign est  = 61'(part[35:6]) * 61'(RecipM);
  assign back = 36'(qd_q) * 36'(UsPerS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      dig_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        dig_q   <= '0;
      end else if (busy_q) begin
        phase_q <= ~phase_q;
        if (phase_q) begin
          dig_q <= dig_q + 1'b1;
          if (dig_q == 2'd3) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIV_W-1];
      mag_q <= dividend_i[DIV_W-1] ? DIV_W'(-dividend_i) : DIV_W'(dividend_i);
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      if (!phase_q) begin
        qd_q <= est[59:44];
      end else begin
        rem_q <= 20'(part - back);
        mag_q <= {mag_q[DIV_W-17:0], 16'd0};
        quo_q <= {quo_q[DIV_W-17:0], qd_q};
      end
    end
  end

  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign done_o = done_q;

endmodule

@@ rtl/odo_dp.sv @@
module odo_dp import odo_pkg::*; #(
  parameter int unsigned CordicIter = CORDIC_ITER_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [19:0]        cfg_wdata_i,
  input  logic               command_i,
  input  logic [31:0]        time_us_i,
  input  logic signed [31:0] left_wheel_i,
  input  logic signed [31:0] right_wheel_i,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [31:0]        heading_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] linear_speed_o,
  output logic signed [31:0] yaw_rate_o,
  output logic               status_o
);

  localparam int unsigned CntW = $clog2(CordicIter);

  op_e op;
  assign op = cmd_i.op;

  // Architectural state.
  logic [19:0]        wb_q;
  logic [31:0]        last_q, hd_q;
  logic signed [31:0] px_q, py_q;
  logic [CntW-1:0]    cnt_q;

  // Working registers.
  logic               cmd_q;
  logic [31:0]        dt_q, hacc_q;
  logic signed [31:0] l_q, r_q, lin_q, yaw_q, vx_q, vy_q;
  logic signed [69:0] prod_q;
  logic signed [63:0] rad_q;
  logic signed [35:0] cx_q, cy_q;
  logic signed [33:0] cz_q;

  // Shared multiplier.
  logic signed [35:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [69:0] prod_d;
  logic               mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (op)
      OP_MUL_L: begin
        mul_a = 36'(l_q);
        mul_b = 34'(US_PER_S);
      end
      OP_MUL_R: begin
        mul_a = 36'(r_q);
        mul_b = 34'(US_PER_S);
      end
      OP_MUL_GX: begin
        mul_a = cx_q;
        mul_b = 34'(CORDIC_GAIN);
      end
      OP_MUL_GY: begin
        mul_a = cy_q;
        mul_b = 34'(CORDIC_GAIN);
      end
      OP_MUL_PX: begin
        mul_a = 36'(vx_q);
        mul_b = $signed({2'b00, dt_q});
      end
      OP_MUL_PY: begin
        mul_a = 36'(vy_q);
        mul_b = $signed({2'b00, dt_q});
      end
      OP_MUL_YT: begin
        mul_a = 36'(yaw_q);
        mul_b = $signed({2'b00, dt_q});
      end
      OP_MUL_HH: begin
        mul_a = 36'($signed(rad_q[47:16]));
        mul_b = 34'(RAD_TO_BAM);
      end
      OP_MUL_HL: begin
        mul_a = $signed({20'd0, rad_q[15:0]});
        mul_b = 34'(RAD_TO_BAM);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod_d = 70'(mul_a) * 70'(mul_b);

  // Divider operand selection.
  logic                    div_start, div_done;
  logic signed [DIV_W-1:0] div_num, quo;
  logic [DVS_W-1:0]        div_den;
  logic signed [32:0]      wdiff;

  assign wdiff = 33'(r_q) - 33'(l_q);

  always_comb begin
    div_start = 1'b1;
    div_num   = prod_q[63:0];
    div_den   = DVS_W'(US_PER_S);
    case (op)
      OP_DIV_DT: div_den = dt_q;
      OP_DIV_YAW: begin
        div_num = 64'($signed({wdiff, 16'd0}));
        div_den = (wb_q == 20'd0) ? DVS_W'(1) : DVS_W'(wb_q);
      end
      default:   div_start = 1'b0;
    endcase
  end

  odo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quo_o      (quo),
    .done_o     (div_done)
  );

  // Products over the interval are scaled from microseconds to seconds here.
  logic                    us_start, us_done;
  logic signed [DIV_W-1:0] quo_us;

  assign us_start = (op == OP_DIV_US);

  odo_div_us u_div_us (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (us_start),
    .dividend_i (prod_q[63:0]),
    .quo_o      (quo_us),
    .done_o     (us_done)
  );

  // CORDIC step terms.
  logic signed [35:0] sh_x, sh_y;
  logic signed [33:0] atan_s;
  logic               fold;
  logic [31:0]        hsum, zr;
  logic signed [32:0] lsum, lsum_r;

  assign sh_x   = cx_q >>> cnt_q;
  assign sh_y   = cy_q >>> cnt_q;
  assign atan_s = $signed({2'b00, atan_bam(5'(cnt_q))});
  assign hsum   = hd_q + 32'h4000_0000;
  assign fold   = hsum[31];
  assign zr     = fold ? (hd_q ^ 32'h8000_0000) : hd_q;
  assign lsum   = 33'(l_q) + 33'(r_q);
  assign lsum_r = lsum + $signed({32'd0, lsum[32]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q   <= WB_RESET;
      last_q <= '0;
      px_q   <= '0;
      py_q   <= '0;
      hd_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        wb_q <= cfg_wdata_i;
      end
      case (op)
        OP_LOAD:   last_q <= time_us_i;
        OP_CINIT:  cnt_q <= '0;
        OP_CITER:  cnt_q <= cnt_q + 1'b1;
        OP_GET_PX: px_q <= sat32(64'(px_q) + quo_us);
        OP_GET_PY: py_q <= sat32(64'(py_q) + quo_us);
        OP_ADD_H:  hd_q <= hd_q + hacc_q + prod_q[47:16];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= prod_d;
    end
    case (op)
      OP_LOAD: begin
        cmd_q <= command_i;
        l_q   <= left_wheel_i;
        r_q   <= right_wheel_i;
        dt_q  <= time_us_i - last_q;
      end
      OP_GET_L: l_q <= sat32(quo);
      OP_GET_R: r_q <= sat32(quo);
      OP_GET_YAW: begin
        yaw_q <= sat32(quo);
        lin_q <= lsum_r[32:1];
      end
      OP_CINIT: begin
        cx_q <= fold ? -36'(lin_q) : 36'(lin_q);
        cy_q <= '0;
        cz_q <= 34'($signed(zr));
      end
      OP_CITER: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - sh_y;
          cy_q <= cy_q + sh_x;
          cz_q <= cz_q - atan_s;
        end else begin
          cx_q <= cx_q + sh_y;
          cy_q <= cy_q - sh_x;
          cz_q <= cz_q + atan_s;
        end
      end
      OP_MUL_GY:  vx_q <= sat32(64'($signed(prod_q[69:30])));
      OP_GET_VY:  vy_q <= sat32(64'($signed(prod_q[69:30])));
      OP_GET_RAD: rad_q <= quo_us;
      OP_MUL_HL:  hacc_q <= prod_q[31:0];
      OP_OUT: begin
        pos_x_o        <= px_q;
        pos_y_o        <= py_q;
        heading_o      <= hd_q;
        vel_x_o        <= (dt_q == 32'd0) ? 32'sd0 : vx_q;
        vel_y_o        <= (dt_q == 32'd0) ? 32'sd0 : vy_q;
        linear_speed_o <= (dt_q == 32'd0) ? 32'sd0 : lin_q;
        yaw_rate_o     <= (dt_q == 32'd0) ? 32'sd0 : yaw_q;
        status_o       <= (dt_q == 32'd0);
      end
      default: ;
    endcase
  end

  assign stat_o.dt_zero     = (dt_q == 32'd0);
  assign stat_o.cmd         = cmd_q;
  assign stat_o.div_done    = div_done | us_done;
  assign stat_o.cordic_last = (cnt_q == CntW'(CordicIter - 1));

endmodule

@@ rtl/odo_ctrl.sv @@
module odo_ctrl import odo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   can_out;

  assign can_out = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CHECK;
      S_CHECK: begin
        if (stat_i.dt_zero) begin
          state_d = S_OUT;
        end else if (stat_i.cmd) begin
          state_d = S_ML;
        end else begin
          state_d = S_DY;
        end
      end
      S_ML:  state_d = S_DL;
      S_DL:  state_d = S_WL;
      S_WL:  if (stat_i.div_done) state_d = S_GL;
      S_GL:  state_d = S_MR;
      S_MR:  state_d = S_DR;
      S_DR:  state_d = S_WR;
      S_WR:  if (stat_i.div_done) state_d = S_GR;
      S_GR:  state_d = S_DY;
      S_DY:  state_d = S_WY;
      S_WY:  if (stat_i.div_done) state_d = S_GY;
      S_GY:  state_d = S_CI;
      S_CI:  state_d = S_CR;
      S_CR:  if (stat_i.cordic_last) state_d = S_GX;
      S_GX:  state_d = S_GG;
      S_GG:  state_d = S_VY;
      S_VY:  state_d = S_MPX;
      S_MPX: state_d = S_DPX;
      S_DPX: state_d = S_WPX;
      S_WPX: if (stat_i.div_done) state_d = S_GPX;
      S_GPX: state_d = S_MPY;
      S_MPY: state_d = S_DPY;
      S_DPY: state_d = S_WPY;
      S_WPY: if (stat_i.div_done) state_d = S_GPY;
      S_GPY: state_d = S_MYT;
      S_MYT: state_d = S_DYT;
      S_DYT: state_d = S_WYT;
      S_WYT: if (stat_i.div_done) state_d = S_GRD;
      S_GRD: state_d = S_HH;
      S_HH:  state_d = S_HL;
      S_HL:  state_d = S_HA;
      S_HA:  state_d = S_OUT;
      S_OUT: if (can_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      S_IDLE:  if (in_valid_i) cmd_o.op = OP_LOAD;
      S_ML:    cmd_o.op = OP_MUL_L;
      S_DL:    cmd_o.op = OP_DIV_DT;
      S_GL:    cmd_o.op = OP_GET_L;
      S_MR:    cmd_o.op = OP_MUL_R;
      S_DR:    cmd_o.op = OP_DIV_DT;
      S_GR:    cmd_o.op = OP_GET_R;
      S_DY:    cmd_o.op = OP_DIV_YAW;
      S_GY:    cmd_o.op = OP_GET_YAW;
      S_CI:    cmd_o.op = OP_CINIT;
      S_CR:    cmd_o.op = OP_CITER;
      S_GX:    cmd_o.op = OP_MUL_GX;
      S_GG:    cmd_o.op = OP_MUL_GY;
      S_VY:    cmd_o.op = OP_GET_VY;
      S_MPX:   cmd_o.op = OP_MUL_PX;
      S_DPX:   cmd_o.op = OP_DIV_US;
      S_GPX:   cmd_o.op = OP_GET_PX;
      S_MPY:   cmd_o.op = OP_MUL_PY;
      S_DPY:   cmd_o.op = OP_DIV_US;
      S_GPY:   cmd_o.op = OP_GET_PY;
      S_MYT:   cmd_o.op = OP_MUL_YT;
      S_DYT:   cmd_o.op = OP_DIV_US;
      S_GRD:   cmd_o.op = OP_GET_RAD;
      S_HH:    cmd_o.op = OP_MUL_HH;
      S_HL:    cmd_o.op = OP_MUL_HL;
      S_HA:    cmd_o.op = OP_ADD_H;
      S_OUT:   if (can_out) cmd_o.op = OP_OUT;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && can_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/differential_drive_odometry_top.sv @@
// Dead-reckoning odometry for a two-wheel differential robot. Each input word
// carries a microsecond timestamp and the left and right wheel values in
// Q16.16, either velocities (command 0) or distances (command 1). The block
// forms the interval from the previous timestamp, derives forward speed and
// yaw rate, rotates the speed into the world frame by the current heading with
// an iterative CORDIC, and integrates x, y (saturating) and the heading (a
// binary angle that wraps). A zero interval leaves the pose alone and returns
// status 1 with zero rates. One word is processed at a time: the input is not
// ready again until the word's result is in the output register. Most of the
// time goes to the shared one-bit-per-cycle divider, which does each division
// by the wheelbase or by the interval (one for yaw rate, two more for
// distances); the three scalings by one million use a separate divider that
// works in 16-bit digits. The result sits in an output register, so the next
// input word is taken while the previous result still waits; that next word
// then holds in its last cycle until the waiting result is taken. The
// wheelbase register may be written only while the block is idle; a zero
// wheelbase is treated as one.
module differential_drive_odometry_top import odo_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [19:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [31:0]        time_us_i,
  input  logic signed [31:0] left_wheel_i,
  input  logic signed [31:0] right_wheel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [31:0]        heading_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] linear_speed_o,
  output logic signed [31:0] yaw_rate_o,
  output logic               status_o
);

  // The controller sequences one datapath operation per cycle and waits on
  // the divider and CORDIC status and on a free output register.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  odo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the pose, the wheelbase, the shared multiplier, the
  // dividers and the CORDIC registers.
  odo_dp #(
    .CordicIter (CORDIC_ITERATIONS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .command_i      (command_i),
    .time_us_i      (time_us_i),
    .left_wheel_i   (left_wheel_i),
    .right_wheel_i  (right_wheel_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .heading_o      (heading_o),
    .vel_x_o        (vel_x_o),
    .vel_y_o        (vel_y_o),
    .linear_speed_o (linear_speed_o),
    .yaw_rate_o     (yaw_rate_o),
    .status_o       (status_o)
  );

endmodule

@@ rtl/odo_chk.sv @@
`include "assert_macros.svh"

module odo_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] pos_x_o,
  input logic [31:0]        heading_o,
  input logic signed [31:0] vel_x_o,
  input logic signed [31:0] vel_y_o,
  input logic signed [31:0] linear_speed_o,
  input logic signed [31:0] yaw_rate_o,
  input logic               status_o
);

  // A word is worked on alone, so the input side closes right after a word.
  `ODO_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o)

  // A zero interval reports no motion.
  `ODO_ASSERT(a_zero_interval, out_valid_o && status_o |-> vel_x_o == 0 && vel_y_o == 0 &&
    linear_speed_o == 0 && yaw_rate_o == 0)

  // A new result appears only at the end of a word's work.
  `ODO_ASSERT(a_result_after_work, $rose(out_valid_o) |-> $past(!in_ready_o))

  // A stalled result is held.
  `ODO_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(heading_o))

endmodule

bind differential_drive_odometry_top odo_chk u_odo_chk (.*);

@@ tb/sv/tb_differential_drive_odometry_top.sv @@
module tb_differential_drive_odometry_top;
  import odo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_RANDOM = 930;
  localparam longint unsigned CYCLE_LIMIT = 64'd4000000;

  // One expected output word of the odometry block.
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0]        hd;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] lin;
    logic signed [31:0] yaw;
    logic               st;
  } pose_word_t;

  // The scoreboard tracks the robot pose itself and holds the pose words that
  // the block still owes.
  class pose_tracker;
    pose_word_t pending[$];
    logic [19:0] wheelbase;
    logic [31:0] last_time;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0] hd;
    int errors;

    function void reset_state();
      wheelbase = WB_RESET;
      last_time = '0;
      px = '0;
      py = '0;
      hd = '0;
    endfunction

    static function longint floor_sh(longint a, int s);
      return a >>> s;
    endfunction

    static function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Rotate (v, 0) by a binary angle with a rotation-mode CORDIC.
    static function void turn(longint v, logic [31:0] ang, output longint ox,
                              output longint oy);
      longint x, y, z, t, dx, dy;
      logic [31:0] zr;
      x = v;
      y = 0;
      zr = ang;
      if (((ang + 32'h4000_0000) & 32'h8000_0000) != 0) begin
        x = -x;
        zr = ang + 32'h8000_0000;
      end
      z = longint'($signed(zr));
      for (int i = 0; i < CORDIC_ITER_DEF && i < 32; i++) begin
        dx = floor_sh(y, i);
        dy = floor_sh(x, i);
        if (z >= 0) begin
          t = x - dx; y = y + dy; z = z - longint'(atan_bam(5'(i)));
        end else begin
          t = x + dx; y = y - dy; z = z + longint'(atan_bam(5'(i)));
        end
        x = t;
      end
      ox = clamp32(floor_sh(x * longint'(CORDIC_GAIN), 30));
      oy = clamp32(floor_sh(y * longint'(CORDIC_GAIN), 30));
    endfunction

    function void note_input(logic cmd, logic [31:0] now, logic signed [31:0] lw,
                             logic signed [31:0] rw);
      pose_word_t w;
      longint l, r, lin, yaw, wb, rad, rh, rl, vx, vy, dtl;
      logic [31:0] dt;
      logic [63:0] bam;
      dt = now - last_time;
      last_time = now;
      w.px = px; w.py = py; w.hd = hd;
      w.vx = 0; w.vy = 0; w.lin = 0; w.yaw = 0; w.st = 1'b1;
      if (dt != 0) begin
        dtl = longint'(dt);
        l = lw;
        r = rw;
        if (cmd) begin
          l = clamp32((l * 1000000) / dtl);
          r = clamp32((r * 1000000) / dtl);
        end
        lin = (l + r) / 2;
        wb = (wheelbase != 0) ? longint'(wheelbase) : 1;
        yaw = clamp32(((r - l) * 65536) / wb);
        turn(lin, hd, vx, vy);
        px = 32'(clamp32(longint'(px) + (vx * dtl) / 1000000));
        py = 32'(clamp32(longint'(py) + (vy * dtl) / 1000000));
        rad = (yaw * dtl) / 1000000;
        rh = floor_sh(rad, 16);
        rl = rad & 64'hFFFF;
        bam = rh * longint'(RAD_TO_BAM) + ((rl * longint'(RAD_TO_BAM)) >>> 16);
        hd = hd + bam[31:0];
        w.px = px; w.py = py; w.hd = hd;
        w.vx = 32'(vx); w.vy = 32'(vy); w.lin = 32'(lin); w.yaw = 32'(yaw); w.st = 1'b0;
      end
      pending.push_back(w);
    endfunction

    function void check_output(pose_word_t got);
      pose_word_t e;
      if (pending.size() == 0) begin
        $error("output word with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.px !== e.px) begin $error("pos_x exp %0d got %0d", e.px, got.px); errors++; end
      if (got.py !== e.py) begin $error("pos_y exp %0d got %0d", e.py, got.py); errors++; end
      if (got.hd !== e.hd) begin $error("heading exp %0d got %0d", e.hd, got.hd); errors++; end
      if (got.vx !== e.vx) begin $error("vel_x exp %0d got %0d", e.vx, got.vx); errors++; end
      if (got.vy !== e.vy) begin $error("vel_y exp %0d got %0d", e.vy, got.vy); errors++; end
      if (got.lin !== e.lin) begin
        $error("linear_speed exp %0d got %0d", e.lin, got.lin); errors++;
      end
      if (got.yaw !== e.yaw) begin
        $error("yaw_rate exp %0d got %0d", e.yaw, got.yaw); errors++;
      end
      if (got.st !== e.st) begin $error("status exp %0d got %0d", e.st, got.st); errors++; end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [19:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic command_i = 1'b0;
  logic [31:0] time_us_i = '0;
  logic signed [31:0] left_wheel_i = '0;
  logic signed [31:0] right_wheel_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o, vel_x_o, vel_y_o, linear_speed_o, yaw_rate_o;
  logic [31:0] heading_o;
  logic status_o;

  pose_tracker board = new();
  logic [31:0] clock_us = '0;
  longint unsigned cycles = 0;

  always #6 clk_i = ~clk_i;

  differential_drive_odometry_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .command_i(command_i), .time_us_i(time_us_i),
    .left_wheel_i(left_wheel_i), .right_wheel_i(right_wheel_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .pos_x_o(pos_x_o), .pos_y_o(pos_y_o), .heading_o(heading_o),
    .vel_x_o(vel_x_o), .vel_y_o(vel_y_o), .linear_speed_o(linear_speed_o),
    .yaw_rate_o(yaw_rate_o), .status_o(status_o)
  );

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Present one input word and hold it until the block takes it. The scoreboard
  // learns about the word at the accepting edge, in the same order the block
  // sees it.
  task automatic send_word(logic cmd, logic [31:0] t, logic signed [31:0] lw,
                           logic signed [31:0] rw);
    in_valid_i <= 1'b1;
    command_i <= cmd;
    time_us_i <= t;
    left_wheel_i <= lw;
    right_wheel_i <= rw;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(cmd, t, lw, rw);
  endtask

  task automatic send_gap();
    int g;
    g = pick_gap();
    if (g == 0) return;
    in_valid_i <= 1'b0;
    repeat (g) @(posedge clk_i);
  endtask

  // Wait until every pending word has come out, then give the block time to
  // settle before a register write.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_wheelbase(logic [19:0] wb);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= wb;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.wheelbase = wb;
    @(posedge clk_i);
  endtask

  // Random wheel value: mostly a plausible speed, sometimes an extreme or any 32-bit value.
  function automatic logic signed [31:0] pick_wheel();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    if (k < 8) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_step();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 32'd0;
    if (k == 1) return $urandom();
    if (k < 4) return $urandom_range(1, 10);
    return $urandom_range(100, 50000);
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      clock_us = clock_us + pick_step();
      send_word(1'($urandom_range(0, 1)), clock_us, pick_wheel(), pick_wheel());
      send_gap();
    end
  endtask

  // Receiver side: stalls at random and checks every word it takes.
  initial begin
    pose_word_t got;
    int g;
    wait (rst_ni);
    forever begin
      g = pick_gap();
      if (g != 0 && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      if (out_valid_o) begin
        got.px = pos_x_o; got.py = pos_y_o; got.hd = heading_o;
        got.vx = vel_x_o; got.vy = vel_y_o; got.lin = linear_speed_o;
        got.yaw = yaw_rate_o; got.st = status_o;
        board.check_output(got);
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    board.reset_state();
    board.errors = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset wheelbase: a zero interval first, then the
    // extremes of the wheel values in both command modes.
    send_word(1'b0, 32'd0, 32'sh0001_0000, 32'sh0001_0000);
    send_word(1'b0, 32'd1000, 32'sh0001_0000, 32'sh0001_0000);
    send_word(1'b1, 32'd2000, 32'sh0000_0100, 32'sh0000_0200);
    send_word(1'b0, 32'd3000, 32'sh0000_0000, 32'sh0004_0000);
    send_word(1'b0, 32'd500000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_word(1'b0, 32'd900000, 32'sh8000_0000, 32'sh8000_0000);
    send_word(1'b0, 32'd900000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_word(1'b1, 32'd900001, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_word(1'b1, 32'd0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_word(1'b0, 32'hFFFF_FFFF, 32'sh0002_0000, -32'sh0002_0000);
    send_word(1'b1, 32'hFFFF_FFFF, 32'sh0002_0000, -32'sh0002_0000);
    send_word(1'b0, 32'h8000_0000, -32'sh0000_0001, 32'sh0000_0001);
    // Drive a tight arc for a while so the heading wraps through every quadrant.
    for (int i = 0; i < 8; i++) begin
      send_word(1'b0, 32'h8000_0000 + 32'(i + 1) * 32'd200000, 32'sh0003_0000,
                32'sh0006_0000);
    end
    clock_us = 32'h8000_0000 + 32'd1600000;
    drain();

    // Wheelbase extremes, zero among them, then random phases at each setting.
    write_wheelbase(20'd0);
    send_word(1'b0, clock_us + 32'd10, 32'sh0000_0001, 32'sh0000_0002);
    send_word(1'b0, clock_us + 32'd20, 32'sh8000_0000, 32'sh7FFF_FFFF);
    clock_us = clock_us + 32'd20;
    random_phase(150);
    drain();
    write_wheelbase(20'd1);
    random_phase(150);
    drain();
    write_wheelbase(20'hFFFFF);
    random_phase(150);
    drain();
    write_wheelbase(20'd655360);
    random_phase(150);
    drain();
    write_wheelbase(20'($urandom_range(1, 655360)));
    random_phase(150);
    drain();
    write_wheelbase(20'd32768);
    random_phase(N_RANDOM - 750);
    in_valid_i <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
